@@ design/vfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Viterbi FEC decoder package
// Shared types, trellis constants and small helper functions.
// ----------------------------------------------------------------------------
package vfd_pkg;

  localparam int NUM_STATES     = 8;
  localparam int STEPS_PER_WORD = 16;
  localparam int STEP_W         = 4;
  localparam int MAX_RESULTS    = 5;
  localparam int OQ_DEPTH       = 8;
  localparam int OQ_AW          = 3;
  localparam int OQ_CW          = 4;

  localparam logic [7:0] INIT_METRIC = 8'd100;

  typedef logic [1:0] sym_t;

  // expected symbol on the branch into state d, from source d>>1 and (d>>1)+4
  localparam sym_t BRANCH_SYM [NUM_STATES][2] = '{
    '{2'd0, 2'd3}, '{2'd3, 2'd0}, '{2'd1, 2'd2}, '{2'd2, 2'd1},
    '{2'd3, 2'd0}, '{2'd0, 2'd3}, '{2'd2, 2'd1}, '{2'd1, 2'd2}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_NORM
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
    logic norm;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic flush_hit;
    logic flush_more;
  } stat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } res_t;

  function automatic logic [1:0] sym_dist(sym_t a, sym_t b);
    sym_t x;
    x = a ^ b;
    return {1'b0, x[0]} + {1'b0, x[1]};
  endfunction

  // reorder so that trellis symbol s sits in bits 31-2s..30-2s
  function automatic logic [31:0] deinterleave(logic [31:0] w);
    logic [31:0] r;
    r = '0;
    for (int s = 0; s < STEPS_PER_WORD; s++) begin
      r[30 - 2 * s +: 2] = w[8 * (3 - (s % 4)) + 2 * (s / 4) +: 2];
    end
    return r;
  endfunction

endpackage

@@ design/viterbi_fec_decoder.sv @@
// ----------------------------------------------------------------------------
// Viterbi FEC decoder, rate 1/2, 8 states, hard decision
// Decodes interleaved 4-byte coded words into payload bytes.
// ----------------------------------------------------------------------------
// A coded word is taken while the controller is idle, then the single 8-way
// add-compare-select unit runs one trellis step per cycle for the 16 symbols
// of the word, followed by metric normalization. At the end of a packet the
// flush replaces the remaining steps and normalization. A word that arrives
// when no packet is open is consumed but yields no beat.
// Decoded bytes go to an 8-entry output queue; a new word is taken only when
// the queue has room for the five bytes one word can produce.
module viterbi_fec_decoder #(
  parameter int PATH_BITS         = 32,
  parameter int MAX_MESSAGE_BYTES = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_coded_word,
  input  logic        in_packet_start,
  input  logic [9:0]  in_message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_decoded_byte,
  output logic        out_last_of_word,
  output logic        out_packet_done
);
  import vfd_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  room;
  logic  push;
  res_t  push_res;
  res_t  out_res;

  vfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .room     (room),
    .stat     (stat),
    .cmd      (cmd)
  );

  vfd_datapath #(
    .PATH_BITS         (PATH_BITS),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_coded_word     (in_coded_word),
    .in_packet_start   (in_packet_start),
    .in_message_length (in_message_length),
    .cmd               (cmd),
    .stat              (stat),
    .push              (push),
    .push_res          (push_res)
  );

  vfd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_decoded_byte = out_res.data;
  assign out_last_of_word = out_res.last;
  assign out_packet_done  = out_res.done;

endmodule

@@ design/vfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Viterbi FEC decoder controller
// Sequences load, trellis steps, flush and normalization of one coded word.
// ----------------------------------------------------------------------------
module vfd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           room,
  input  vfd_pkg::stat_t stat,
  output vfd_pkg::cmd_t  cmd
);
  import vfd_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept && stat.go) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + STEP_W'(1);
        if (stat.flush_hit) begin
          state_nxt = ST_FLUSH;
        end else if (step_r == STEP_W'(STEPS_PER_WORD - 1)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_FLUSH: begin
        if (!stat.flush_more) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NORM: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = room;
        cmd.load = accept;
      end
      ST_RUN:   cmd.step  = 1'b1;
      ST_FLUSH: cmd.flush = 1'b1;
      ST_NORM:  cmd.norm  = 1'b1;
      default:  cmd       = '0;
    endcase
  end

endmodule

@@ design/vfd_datapath.sv @@
// ----------------------------------------------------------------------------
// Viterbi FEC decoder datapath
// Path metrics, survivor paths, 8-way add-compare-select, byte extraction.
// ----------------------------------------------------------------------------
module vfd_datapath #(
  parameter int PATH_BITS         = 32,
  parameter int MAX_MESSAGE_BYTES = 1023
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    in_coded_word,
  input  logic           in_packet_start,
  input  logic [9:0]     in_message_length,
  input  vfd_pkg::cmd_t  cmd,
  output vfd_pkg::stat_t stat,
  output logic           push,
  output vfd_pkg::res_t  push_res
);
  import vfd_pkg::*;

  localparam int BR_W   = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CMP_W  = (BR_W > 10) ? BR_W : 10;
  localparam int HELD_W = $clog2(PATH_BITS + 1);
  localparam int IDX_W  = $clog2(PATH_BITS);

  logic [7:0]           metric_r [NUM_STATES];
  logic [7:0]           metric_nxt [NUM_STATES];
  logic [PATH_BITS-1:0] path_r [NUM_STATES];
  logic [PATH_BITS-1:0] path_nxt [NUM_STATES];
  logic [31:0]          sym_r, sym_nxt;
  logic [HELD_W-1:0]    held_r, held_nxt;
  logic [BR_W-1:0]      br_r, br_nxt;
  logic                 fin_r, fin_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [7:0]           pend_byte_r, pend_byte_nxt;

  logic [7:0]           nm [NUM_STATES];
  logic [PATH_BITS-1:0] np [NUM_STATES];
  logic [PATH_BITS-1:0] src_path [NUM_STATES];
  logic [7:0]           c0 [NUM_STATES];
  logic [7:0]           c1 [NUM_STATES];
  sym_t                 sym;
  logic [CMP_W-1:0]     len_ext;
  logic [BR_W-1:0]      len_sat;
  logic [HELD_W-1:0]    held_inc, held_after;
  logic [BR_W-1:0]      br_after;
  logic                 emit;
  logic [IDX_W-1:0]     fidx;
  logic [7:0]           flush_byte;
  logic [7:0]           min_m;

  assign sym     = sym_r[31:30];
  assign len_ext = CMP_W'(in_message_length);
  assign len_sat = (len_ext > CMP_W'(MAX_MESSAGE_BYTES)) ? BR_W'(MAX_MESSAGE_BYTES)
                                                         : BR_W'(len_ext);

  always_comb begin
    for (int d = 0; d < NUM_STATES; d++) begin
      c0[d] = metric_r[d / 2] + {6'd0, sym_dist(sym, BRANCH_SYM[d][0])};
      c1[d] = metric_r[d / 2 + 4] + {6'd0, sym_dist(sym, BRANCH_SYM[d][1])};
      if (c0[d] <= c1[d]) begin
        nm[d]       = c0[d];
        src_path[d] = path_r[d / 2];
      end else begin
        nm[d]       = c1[d];
        src_path[d] = path_r[d / 2 + 4];
      end
      np[d] = {src_path[d][PATH_BITS-2:0], 1'(d % 2)};
    end
  end

  always_comb begin
    min_m = 8'hFF;
    for (int d = 0; d < NUM_STATES; d++) begin
      if (metric_r[d] < min_m) begin
        min_m = metric_r[d];
      end
    end
  end

  assign held_inc   = held_r + HELD_W'(1);
  assign emit       = (held_inc == HELD_W'(PATH_BITS));
  assign held_after = emit ? (held_inc - HELD_W'(8)) : held_inc;
  assign br_after   = (emit && br_r != '0) ? (br_r - BR_W'(1)) : br_r;
  assign fidx       = IDX_W'(held_r - HELD_W'(8));
  assign flush_byte = path_r[0][fidx +: 8];

  assign stat.go         = in_packet_start ? (len_sat != '0) : !fin_r;
  assign stat.flush_hit  = (br_after <= BR_W'(3)) &&
                           (held_after == ((HELD_W'(br_after) << 3) + HELD_W'(3)));
  assign stat.flush_more = (held_r >= HELD_W'(8));

  always_comb begin
    metric_nxt     = metric_r;
    path_nxt       = path_r;
    sym_nxt        = sym_r;
    held_nxt       = held_r;
    br_nxt         = br_r;
    fin_nxt        = fin_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    push           = 1'b0;
    push_res       = '{data: pend_byte_r, last: 1'b0, done: 1'b0};

    if (cmd.load) begin
      sym_nxt = deinterleave(in_coded_word);
      if (in_packet_start) begin
        for (int d = 0; d < NUM_STATES; d++) begin
          metric_nxt[d] = (d == 0) ? 8'd0 : INIT_METRIC;
          path_nxt[d]   = '0;
        end
        held_nxt = '0;
        br_nxt   = len_sat;
        fin_nxt  = (len_sat == '0);
      end
    end

    if (cmd.step) begin
      metric_nxt = nm;
      path_nxt   = np;
      sym_nxt    = {sym_r[29:0], 2'b00};
      held_nxt   = held_after;
      br_nxt     = br_after;
      if (emit) begin
        push           = pend_valid_r;
        pend_valid_nxt = 1'b1;
        pend_byte_nxt  = np[0][PATH_BITS-1 -: 8];
      end
    end

    if (cmd.flush) begin
      if (held_r >= HELD_W'(8)) begin
        push           = pend_valid_r;
        pend_valid_nxt = 1'b1;
        pend_byte_nxt  = flush_byte;
        held_nxt       = held_r - HELD_W'(8);
        br_nxt         = (br_r != '0) ? (br_r - BR_W'(1)) : br_r;
      end else begin
        fin_nxt        = 1'b1;
        push           = pend_valid_r;
        push_res.last  = 1'b1;
        push_res.done  = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end

    if (cmd.norm) begin
      for (int d = 0; d < NUM_STATES; d++) begin
        metric_nxt[d] = metric_r[d] - min_m;
      end
      push           = pend_valid_r;
      push_res.last  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      br_r         <= '0;
      fin_r        <= 1'b1;
      pend_valid_r <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      br_r         <= br_nxt;
      fin_r        <= fin_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    metric_r    <= metric_nxt;
    path_r      <= path_nxt;
    sym_r       <= sym_nxt;
    pend_byte_r <= pend_byte_nxt;
  end

endmodule

@@ design/vfd_outq.sv @@
// ----------------------------------------------------------------------------
// Viterbi FEC decoder output queue
// Eight-entry FIFO of decoded bytes; reports room for one full coded word.
// ----------------------------------------------------------------------------
module vfd_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vfd_pkg::res_t push_res,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output vfd_pkg::res_t out_res
);
  import vfd_pkg::*;

  res_t             mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_r, rd_r;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= OQ_CW'(OQ_DEPTH - MAX_RESULTS));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + OQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + OQ_AW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_res;
    end
  end

endmodule
